/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLUT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define CLUT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hdl/clut_pkg.sv */
package clut_pkg;

  localparam int IDX_W      = 8;
  localparam int WORD_W     = 16;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TEXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CMODE_IDX4 = 2'd0;
  localparam logic [CFG_DATA_W-1:0] CMODE_IDX8 = 2'd1;
  localparam logic [CFG_DATA_W-1:0] AMODE_HALF = 2'd0;

  localparam logic [CH_W-1:0] ALPHA_NONE = 8'h00;
  localparam logic [CH_W-1:0] ALPHA_HALF = 8'h7F;
  localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

  // round(c * 255 / 31), entry 31 first
  localparam logic [31:0][CH_W-1:0] EXPAND5 = {
    8'd255, 8'd247, 8'd239, 8'd230, 8'd222, 8'd214, 8'd206, 8'd197,
    8'd189, 8'd181, 8'd173, 8'd165, 8'd156, 8'd148, 8'd140, 8'd132,
    8'd123, 8'd115, 8'd107, 8'd99,  8'd90,  8'd82,  8'd74,  8'd66,
    8'd58,  8'd49,  8'd41,  8'd33,  8'd25,  8'd16,  8'd8,   8'd0
  };

  typedef struct packed {
    logic              valid;
    logic              texel;
    logic              direct;
    logic              miss;
    logic [WORD_W-1:0] word;
  } clut_s1_t;

endpackage

/* hdl/clut_ifs.sv */
interface clut_in_if import clut_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  index;
  logic [WORD_W-1:0] data_word;
  logic              upper_nibble;

  modport source (output valid, cmd, index, data_word, upper_nibble, input ready);
  modport sink   (input valid, cmd, index, data_word, upper_nibble, output ready);
endinterface

interface clut_out_if import clut_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface clut_cfg_if import clut_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/clut_pal_mem.sv */
module clut_pal_mem import clut_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/clut_expand.sv */
module clut_expand import clut_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  clut_s1_t              s1,
  input  logic [WORD_W-1:0]     rd_data,
  input  logic [CFG_DATA_W-1:0] alpha_mode,
  output logic                  adv,
  clut_out_if.source            pixel
);

  logic [WORD_W-1:0] color;
  logic [4:0]        r;
  logic [4:0]        g;
  logic [4:0]        b;
  logic [CH_W-1:0]   a;
  logic              valid;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  logic [CH_W-1:0]   alpha;

  assign adv = !valid || pixel.ready;

  always_comb begin
    if (s1.direct) begin
      color = s1.word;
    end else if (s1.miss) begin
      color = '0;
    end else begin
      color = rd_data;
    end
    r = color[4:0];
    g = color[9:5];
    b = color[14:10];
    if (color[15]) begin
      a = (alpha_mode == AMODE_HALF) ? ALPHA_HALF : ALPHA_FULL;
    end else if ({r, g, b} == 15'd0) begin
      a = ALPHA_NONE;
    end else begin
      a = ALPHA_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= EXPAND5[r];
      green <= EXPAND5[g];
      blue  <= EXPAND5[b];
      alpha <= a;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= s1.valid && s1.texel;
    end
  end

  assign pixel.valid = valid;
  assign pixel.red   = red;
  assign pixel.green = green;
  assign pixel.blue  = blue;
  assign pixel.alpha = alpha;

endmodule

/* hdl/clut_texel_expander.sv */
// channel | dir | word                                       | accepted when
// texel   | in  | cmd, index, data_word, upper_nibble        | valid && ready
// pixel   | out | red, green, blue, alpha                    | valid && ready
// cfg     | in  | index, data (0 tex_fmt, 1 alpha_mode)      | valid && ready
//
// One word per cycle while the pixel output is not stalled; a texel's pixel
// passes the palette read (synchronous RAM) and the s1 register at the taking
// edge, then the output register loads when the pipe advances again.
// Loads write the palette in the cycle they are taken and give no pixel.
// rst (synchronous) clears both registers and the pipeline valids; the palette
// is not cleared. A stalled pixel holds the whole pipe; texel.ready drops then.
module clut_texel_expander import clut_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  clut_in_if.sink    texel,
  clut_out_if.source pixel,
  clut_cfg_if.sink   cfg
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int LIM_W = IDX_W + 1;
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(PALETTE_DEPTH);

  logic [CFG_DATA_W-1:0] tex_fmt;
  logic [CFG_DATA_W-1:0] alpha_mode;
  logic                  adv;
  logic                  accept;
  logic [IDX_W-1:0]      lookup_idx;
  logic                  direct;
  logic                  miss;
  logic                  wr_en;
  logic [WORD_W-1:0]     rd_data;
  clut_s1_t              s1;

  assign cfg.ready   = 1'b1;
  assign texel.ready = adv;
  assign accept      = texel.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_fmt    <= CMODE_IDX4;
      alpha_mode <= AMODE_HALF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COLOR_MODE: tex_fmt <= cfg.data;
        REG_ALPHA_MODE: alpha_mode <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    direct     = 1'b0;
    lookup_idx = texel.data_word[IDX_W-1:0];
    unique case (tex_fmt)
      CMODE_IDX4: begin
        lookup_idx = {4'd0, texel.upper_nibble ? texel.data_word[7:4] : texel.data_word[3:0]};
      end
      CMODE_IDX8: begin
        lookup_idx = texel.data_word[IDX_W-1:0];
      end
      default: begin
        direct = 1'b1;
      end
    endcase
  end

  assign miss  = {1'b0, lookup_idx} >= DEPTH_LIM;
  assign wr_en = accept && (texel.cmd == CMD_LOAD) && ({1'b0, texel.index} < DEPTH_LIM);

  clut_pal_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (texel.index[AW-1:0]),
    .wr_data (texel.data_word),
    .rd_en   (adv),
    .rd_addr (lookup_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.texel  <= (texel.cmd == CMD_TEXEL);
      s1.direct <= direct;
      s1.miss   <= miss;
      s1.word   <= texel.data_word;
    end
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= accept;
    end
  end

  clut_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .s1         (s1),
    .rd_data    (rd_data),
    .alpha_mode (alpha_mode),
    .adv        (adv),
    .pixel      (pixel)
  );

endmodule

/* hdl/clut_checker.sv */
`include "assert_macros.svh"

module clut_checker import clut_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_cmd,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_red,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_blue,
  input logic [CH_W-1:0] out_alpha
);

  `CLUT_ASSERT_SAME(a_ready_only_on_stall, clk, rst, !in_ready, out_valid && !out_ready)

  `CLUT_ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !out_valid)

  `CLUT_ASSERT_NEXT(a_texel_to_pixel, clk, rst, (in_valid && in_ready && in_cmd == CMD_TEXEL) ##1 out_ready, out_valid)

  `CLUT_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))

endmodule

bind clut_texel_expander clut_checker u_clut_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (texel.valid),
  .in_ready  (texel.ready),
  .in_cmd    (texel.cmd),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_red   (pixel.red),
  .out_green (pixel.green),
  .out_blue  (pixel.blue),
  .out_alpha (pixel.alpha)
);

/* verif/clut_texel_expander_tb.sv */
`timescale 1ns / 100ps

module clut_texel_expander_tb;
  import clut_pkg::*;

  localparam logic [CFG_DATA_W-1:0] CMODE_DIRECT = 2'd2;
  localparam logic [CFG_DATA_W-1:0] CMODE_SPARE  = 2'd3;
  localparam logic [CFG_DATA_W-1:0] AMODE_FULL_1 = 2'd1;
  localparam logic [CFG_DATA_W-1:0] AMODE_FULL_2 = 2'd2;
  localparam logic [CFG_DATA_W-1:0] AMODE_FULL_3 = 2'd3;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYC   = 6;
  localparam int DIR_N       = 25;
  localparam int RND_PHASES  = 8;
  localparam int RND_PER_PH  = 75;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] data_word;
    logic              upper_nibble;
  } texel_word_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] cm;
    logic [CFG_DATA_W-1:0] am;
    logic                  cmd;
    logic [IDX_W-1:0]      index;
    logic [WORD_W-1:0]     data_word;
    logic                  upper_nibble;
    logic                  typed;
    rgba_t                 px;
  } dir_row_t;

  // typed pixels are 32'hRRGGBBAA
  localparam dir_row_t DIR_TBL [DIR_N] = '{
    '{CMODE_IDX4,   AMODE_HALF,   CMD_LOAD,  8'd0,   16'h0000, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_LOAD,  8'd15,  16'hFFFF, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_LOAD,  8'd255, 16'h7FFF, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_LOAD,  8'd1,   16'h8000, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_TEXEL, 8'd0,   16'h00F0, 1'b0, 1'b1, 32'h00000000},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_TEXEL, 8'd255, 16'h00F0, 1'b1, 1'b1, 32'hFFFFFF7F},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_TEXEL, 8'd0,   16'hFF01, 1'b0, 1'b1, 32'h0000007F},
    '{CMODE_IDX4,   AMODE_HALF,   CMD_TEXEL, 8'd0,   16'h001F, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_TEXEL, 8'd0,   16'hABFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_TEXEL, 8'd0,   16'h000F, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_LOAD,  8'd128, 16'h5294, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_TEXEL, 8'd77,  16'hFF80, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_LOAD,  8'd7,   16'h0001, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX8,   AMODE_FULL_3, CMD_TEXEL, 8'd0,   16'h0007, 1'b0, 1'b0, 32'h0},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'h0000, 1'b0, 1'b1, 32'h00000000},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'hFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'h8000, 1'b1, 1'b1, 32'h000000FF},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'h001F, 1'b0, 1'b1, 32'hFF0000FF},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'h03E0, 1'b0, 1'b1, 32'h00FF00FF},
    '{CMODE_DIRECT, AMODE_FULL_1, CMD_TEXEL, 8'd0,   16'h7C00, 1'b0, 1'b1, 32'h0000FFFF},
    '{CMODE_SPARE,  AMODE_HALF,   CMD_TEXEL, 8'd0,   16'h8000, 1'b0, 1'b1, 32'h0000007F},
    '{CMODE_SPARE,  AMODE_HALF,   CMD_TEXEL, 8'd0,   16'h4210, 1'b1, 1'b0, 32'h0},
    '{CMODE_SPARE,  AMODE_HALF,   CMD_LOAD,  8'd2,   16'h1234, 1'b0, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_FULL_2, CMD_TEXEL, 8'd0,   16'h0020, 1'b1, 1'b0, 32'h0},
    '{CMODE_IDX4,   AMODE_FULL_2, CMD_TEXEL, 8'd0,   16'h0F02, 1'b0, 1'b0, 32'h0}
  };

  logic clk;
  logic rst;

  clut_in_if  texel_if ();
  clut_out_if pixel_if ();
  clut_cfg_if cfg_if ();

  clut_texel_expander i_dut (
    .clk   (clk),
    .rst   (rst),
    .texel (texel_if),
    .pixel (pixel_if),
    .cfg   (cfg_if)
  );

  logic [WORD_W-1:0]     palette_mdl [256];
  bit   [255:0]          loaded_map;
  logic [CFG_DATA_W-1:0] cur_cm;
  logic [CFG_DATA_W-1:0] cur_am;
  rgba_t                 pixel_q [$];
  int                    mismatch_cnt;
  int                    cycle_cnt;
  int                    src_idle_pct;
  int                    snk_idle_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [CH_W-1:0] widen_ch(input logic [4:0] c);
    int v;
    v = (int'(c) * 510 + 31) / 62;
    return v[CH_W-1:0];
  endfunction

  function automatic rgba_t expand_pixel(input logic [WORD_W-1:0] color);
    rgba_t px;
    px.red   = widen_ch(color[4:0]);
    px.green = widen_ch(color[9:5]);
    px.blue  = widen_ch(color[14:10]);
    if (color[15]) begin
      px.alpha = (cur_am == AMODE_HALF) ? ALPHA_HALF : ALPHA_FULL;
    end else begin
      px.alpha = (color[14:0] == '0) ? ALPHA_NONE : ALPHA_FULL;
    end
    return px;
  endfunction

  function automatic logic [IDX_W-1:0] texel_entry(input texel_word_t w);
    if (cur_cm == CMODE_IDX4) begin
      return w.upper_nibble ? IDX_W'(w.data_word[7:4]) : IDX_W'(w.data_word[3:0]);
    end
    return w.data_word[7:0];
  endfunction

  function automatic logic [WORD_W-1:0] fetch_color(input texel_word_t w);
    if (cur_cm == CMODE_IDX4 || cur_cm == CMODE_IDX8) begin
      return palette_mdl[texel_entry(w)];
    end
    return w.data_word;
  endfunction

  function automatic logic [WORD_W-1:0] rand_color();
    logic [WORD_W-1:0] c;
    c = WORD_W'($urandom);
    case ($urandom_range(9))
      0: c[14:0] = '0;
      1: c[14:0] = '1;
      2: begin
        c[4:0]   = {5{c[0]}};
        c[9:5]   = {5{c[5]}};
        c[14:10] = {5{c[10]}};
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic note_mismatch(input rgba_t want, input rgba_t got, input bit orphan);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (orphan) begin
        $display("pixel with nothing pending: r=%02h g=%02h b=%02h a=%02h",
                 got.red, got.green, got.blue, got.alpha);
      end else begin
        $display("pixel mismatch: want r=%02h g=%02h b=%02h a=%02h, got r=%02h g=%02h b=%02h a=%02h",
                 want.red, want.green, want.blue, want.alpha,
                 got.red, got.green, got.blue, got.alpha);
      end
    end
  endtask

  task automatic send_texel(input texel_word_t w, input bit typed, input rgba_t typed_px);
    while ($urandom_range(99) < src_idle_pct) begin
      texel_if.valid <= 1'b0;
      @(posedge clk);
    end
    texel_if.valid        <= 1'b1;
    texel_if.cmd          <= w.cmd;
    texel_if.index        <= w.index;
    texel_if.data_word    <= w.data_word;
    texel_if.upper_nibble <= w.upper_nibble;
    do @(posedge clk); while (!texel_if.ready);
    if (w.cmd == CMD_LOAD) begin
      palette_mdl[w.index] = w.data_word;
      loaded_map[w.index]  = 1'b1;
    end else if (typed) begin
      pixel_q.push_back(typed_px);
    end else begin
      pixel_q.push_back(expand_pixel(fetch_color(w)));
    end
  endtask

  task automatic set_modes(input logic [CFG_DATA_W-1:0] cm, input logic [CFG_DATA_W-1:0] am);
    texel_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_COLOR_MODE;
    cfg_if.data  <= cm;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_ALPHA_MODE;
    cfg_if.data  <= am;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_cm = cm;
    cur_am = am;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (rst) begin
      pixel_if.ready <= 1'b0;
    end else begin
      pixel_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
    if (!rst && pixel_if.valid && pixel_if.ready) begin
      got = '{pixel_if.red, pixel_if.green, pixel_if.blue, pixel_if.alpha};
      if (pixel_q.size() == 0) begin
        note_mismatch('0, got, 1'b1);
      end else begin
        want = pixel_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
          note_mismatch(want, got, 1'b0);
        end
      end
    end
  end

  initial begin
    texel_word_t w;
    dir_row_t    row;
    logic [CFG_DATA_W-1:0] am;
    rst                   = 1'b1;
    texel_if.valid        = 1'b0;
    texel_if.cmd          = CMD_LOAD;
    texel_if.index        = '0;
    texel_if.data_word    = '0;
    texel_if.upper_nibble = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_COLOR_MODE;
    cfg_if.data           = '0;
    loaded_map            = '0;
    cur_cm                = CMODE_IDX4;
    cur_am                = AMODE_HALF;
    src_idle_pct          = 31;
    snk_idle_pct          = 31;
    for (int i = 0; i < 256; i++) palette_mdl[i] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TBL[i];
      if (row.cm != cur_cm || row.am != cur_am) set_modes(row.cm, row.am);
      w = '{row.cmd, row.index, row.data_word, row.upper_nibble};
      send_texel(w, row.typed, row.px);
    end

    for (int p = 0; p < RND_PHASES; p++) begin
      am = CFG_DATA_W'(p * 3);
      set_modes(CFG_DATA_W'(p), am);
      src_idle_pct = (p == 5) ? 0 : 31;
      snk_idle_pct = (p == 5) ? 0 : 31;
      for (int k = 0; k < RND_PER_PH; k++) begin
        w.index        = IDX_W'($urandom);
        w.upper_nibble = 1'($urandom);
        if ($urandom_range(99) < 25) begin
          w.cmd       = CMD_LOAD;
          w.data_word = rand_color();
          if ($urandom_range(1) == 0) w.index = IDX_W'($urandom_range(15));
        end else begin
          w.cmd       = CMD_TEXEL;
          w.data_word = (cur_cm == CMODE_IDX4 || cur_cm == CMODE_IDX8) ?
                        WORD_W'($urandom) : rand_color();
          // never read a palette entry that holds no loaded color
          if ((cur_cm == CMODE_IDX4 || cur_cm == CMODE_IDX8) &&
              !loaded_map[texel_entry(w)]) begin
            w.index     = texel_entry(w);
            w.cmd       = CMD_LOAD;
            w.data_word = rand_color();
          end
        end
        send_texel(w, 1'b0, '0);
      end
    end

    texel_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/clut_pkg.sv
hdl/clut_ifs.sv
hdl/clut_pal_mem.sv
hdl/clut_expand.sv
hdl/clut_texel_expander.sv
hdl/clut_checker.sv
verif/clut_texel_expander_tb.sv
